// File: rtl/far_pkg.sv
// ----------------------------------------------------------------------------
// far_pkg
// Widths, micro-operation codes and the control store for fraction_add_reduce.
// ----------------------------------------------------------------------------
package far_pkg;

	localparam int OPERAND_W = 16;
	localparam int NUM_W     = 2 * OPERAND_W + 1;
	localparam int DEN_W     = 2 * OPERAND_W;
	localparam int PROD_W    = 2 * OPERAND_W;
	localparam int PC_W      = 5;
	localparam int SHIFT_W   = $clog2(NUM_W + 1);
	localparam int DIV_CNT_W = $clog2(NUM_W + 1);

	localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(NUM_W - 1);

	typedef logic [OPERAND_W-1:0] operand_t;
	typedef logic [NUM_W-1:0]     num_t;
	typedef logic [DEN_W-1:0]     den_t;
	typedef logic [PC_W-1:0]      upc_t;

	typedef enum logic [3:0] {
		OP_NOP,
		OP_MUL_AB,
		OP_MAC_BA,
		OP_MUL_D,
		OP_GINIT,
		OP_HALVE_BOTH,
		OP_HALVE_X,
		OP_HALVE_Y,
		OP_SUBSWAP,
		OP_GSHIFT,
		OP_DIV_INIT_N,
		OP_DIV_STEP,
		OP_STORE_NUM,
		OP_STORE_DEN,
		OP_ZERO,
		OP_FINISH
	} uop_t;

	typedef enum logic [2:0] {
		CND_NEVER,
		CND_ALWAYS,
		CND_N_ZERO,
		CND_Y_ZERO,
		CND_BOTH_EVEN,
		CND_X_EVEN,
		CND_Y_EVEN,
		CND_DIV_MORE
	} cond_t;

	typedef struct packed {
		uop_t  op;
		cond_t cond;
		logic  cond_inv;
		upc_t  target;
	} uword_t;

	localparam upc_t L_SUB_LOOP = 5'd7;
	localparam upc_t L_HALVE_Y  = 5'd8;
	localparam upc_t L_GSHIFT   = 5'd10;
	localparam upc_t L_DIV_N    = 5'd12;
	localparam upc_t L_DIV_D    = 5'd14;
	localparam upc_t L_ZERO     = 5'd16;
	localparam upc_t L_FINISH   = 5'd17;

	// Control store. FINISH stays put until the output register can take
	// the result (held in the sequencer).
	function automatic uword_t ucode_rom(input upc_t pc);
		uword_t w;
		w = '{op: OP_NOP, cond: CND_NEVER, cond_inv: 1'b0, target: '0};
		case (pc)
			5'd0:  w = '{OP_MUL_AB,     CND_NEVER,     1'b0, '0};
			5'd1:  w = '{OP_MAC_BA,     CND_NEVER,     1'b0, '0};
			5'd2:  w = '{OP_MUL_D,      CND_NEVER,     1'b0, '0};
			5'd3:  w = '{OP_GINIT,      CND_N_ZERO,    1'b0, L_ZERO};
			5'd4:  w = '{OP_NOP,        CND_Y_ZERO,    1'b0, L_GSHIFT};
			5'd5:  w = '{OP_HALVE_BOTH, CND_BOTH_EVEN, 1'b0, 5'd5};
			5'd6:  w = '{OP_HALVE_X,    CND_X_EVEN,    1'b0, 5'd6};
			5'd7:  w = '{OP_NOP,        CND_Y_ZERO,    1'b0, L_GSHIFT};
			5'd8:  w = '{OP_HALVE_Y,    CND_Y_EVEN,    1'b0, L_HALVE_Y};
			5'd9:  w = '{OP_SUBSWAP,    CND_ALWAYS,    1'b0, L_SUB_LOOP};
			5'd10: w = '{OP_GSHIFT,     CND_NEVER,     1'b0, '0};
			5'd11: w = '{OP_DIV_INIT_N, CND_NEVER,     1'b0, '0};
			5'd12: w = '{OP_DIV_STEP,   CND_DIV_MORE,  1'b0, L_DIV_N};
			5'd13: w = '{OP_STORE_NUM,  CND_NEVER,     1'b0, '0};
			5'd14: w = '{OP_DIV_STEP,   CND_DIV_MORE,  1'b0, L_DIV_D};
			5'd15: w = '{OP_STORE_DEN,  CND_ALWAYS,    1'b0, L_FINISH};
			5'd16: w = '{OP_ZERO,       CND_NEVER,     1'b0, '0};
			5'd17: w = '{OP_FINISH,     CND_NEVER,     1'b0, '0};
			default: w = '{OP_FINISH,   CND_NEVER,     1'b0, '0};
		endcase
		return w;
	endfunction

endpackage

// File: rtl/fraction_add_reduce.sv
// Flow: one transaction at a time; the sequencer and its shared shift-subtract
// divider stay busy until the result sits in the output register, and a new
// transaction is taken as soon as it does.
// Reset: arst_n clears the sequencer and output valid; data registers are not reset.
// ----------------------------------------------------------------------------
// fraction_add_reduce
// Adds two unsigned fractions and reduces the sum by its GCD (binary GCD,
// restoring divider), driven by a microcoded sequencer.
// ----------------------------------------------------------------------------
module fraction_add_reduce (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  far_pkg::operand_t  num_a,
	input  far_pkg::operand_t  den_a,
	input  far_pkg::operand_t  num_b,
	input  far_pkg::operand_t  den_b,
	output logic               out_valid,
	input  logic               out_stall,
	output far_pkg::num_t      sum_num,
	output far_pkg::den_t      sum_den
);
	import far_pkg::*;

	logic                 busy_q;
	upc_t                 pc_q;
	logic                 out_valid_q;
	operand_t             na_q, da_q, nb_q, db_q;
	num_t                 n_q;
	den_t                 d_q;
	num_t                 x_q, y_q;
	logic [SHIFT_W-1:0]   k_q;
	num_t                 dq_q;
	num_t                 rem_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	num_t                 res_num_q;
	den_t                 res_den_q;
	num_t                 sum_num_q;
	den_t                 sum_den_q;

	uword_t               uw;
	logic                 cond_hit;
	logic                 take;
	logic                 in_acc;
	logic                 out_full;
	operand_t             mul_a, mul_b;
	logic [PROD_W-1:0]    prod;
	logic [NUM_W:0]       trial;
	logic [NUM_W:0]       trial_sub;

	assign uw       = ucode_rom(pc_q);
	assign in_stall = busy_q;
	assign in_acc   = in_valid && !busy_q;
	assign out_full = out_valid_q && out_stall;

	always_comb begin
		case (uw.cond)
			CND_NEVER:     cond_hit = 1'b0;
			CND_ALWAYS:    cond_hit = 1'b1;
			CND_N_ZERO:    cond_hit = (n_q == '0);
			CND_Y_ZERO:    cond_hit = (y_q == '0);
			CND_BOTH_EVEN: cond_hit = !x_q[0] && !y_q[0];
			CND_X_EVEN:    cond_hit = !x_q[0];
			CND_Y_EVEN:    cond_hit = !y_q[0];
			CND_DIV_MORE:  cond_hit = (cnt_q != DIV_LAST);
			default:       cond_hit = 1'b0;
		endcase
		take = cond_hit ^ uw.cond_inv;
	end

	always_comb begin
		case (uw.op)
			OP_MUL_AB: begin
				mul_a = na_q;
				mul_b = db_q;
			end
			OP_MAC_BA: begin
				mul_a = nb_q;
				mul_b = da_q;
			end
			default: begin
				mul_a = da_q;
				mul_b = db_q;
			end
		endcase
		prod = PROD_W'(mul_a) * PROD_W'(mul_b);
	end

	assign trial     = {rem_q, dq_q[NUM_W-1]};
	assign trial_sub = trial - {1'b0, x_q};

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			pc_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall)
				out_valid_q <= 1'b0;
			if (!busy_q) begin
				if (in_acc) begin
					busy_q <= 1'b1;
					pc_q   <= '0;
				end
			end else if (uw.op == OP_FINISH) begin
				if (!out_full) begin
					out_valid_q <= 1'b1;
					busy_q      <= 1'b0;
				end
			end else begin
				pc_q <= take ? uw.target : pc_q + 1'b1;
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (in_acc) begin
			na_q <= num_a;
			da_q <= den_a;
			nb_q <= num_b;
			db_q <= den_b;
		end
		if (busy_q) begin
			case (uw.op)
				OP_MUL_AB: n_q <= NUM_W'(prod);
				OP_MAC_BA: n_q <= n_q + NUM_W'(prod);
				OP_MUL_D:  d_q <= DEN_W'(prod);
				OP_GINIT: begin
					x_q <= n_q;
					y_q <= NUM_W'(d_q);
					k_q <= '0;
				end
				OP_HALVE_BOTH: begin
					if (!x_q[0] && !y_q[0]) begin
						x_q <= x_q >> 1;
						y_q <= y_q >> 1;
						k_q <= k_q + 1'b1;
					end
				end
				OP_HALVE_X: begin
					if (!x_q[0])
						x_q <= x_q >> 1;
				end
				OP_HALVE_Y: begin
					if (!y_q[0])
						y_q <= y_q >> 1;
				end
				OP_SUBSWAP: begin
					if (x_q > y_q) begin
						x_q <= y_q;
						y_q <= x_q - y_q;
					end else begin
						y_q <= y_q - x_q;
					end
				end
				OP_GSHIFT: x_q <= x_q << k_q;
				OP_DIV_INIT_N: begin
					dq_q  <= n_q;
					rem_q <= '0;
					cnt_q <= '0;
				end
				OP_DIV_STEP: begin
					if (!trial_sub[NUM_W]) begin
						rem_q <= trial_sub[NUM_W-1:0];
						dq_q  <= {dq_q[NUM_W-2:0], 1'b1};
					end else begin
						rem_q <= trial[NUM_W-1:0];
						dq_q  <= {dq_q[NUM_W-2:0], 1'b0};
					end
					cnt_q <= cnt_q + 1'b1;
				end
				OP_STORE_NUM: begin
					res_num_q <= dq_q;
					dq_q      <= NUM_W'(d_q);
					rem_q     <= '0;
					cnt_q     <= '0;
				end
				OP_STORE_DEN: res_den_q <= dq_q[DEN_W-1:0];
				OP_ZERO: begin
					res_num_q <= '0;
					res_den_q <= DEN_W'(1);
				end
				OP_FINISH: begin
					if (!out_full) begin
						sum_num_q <= res_num_q;
						sum_den_q <= res_den_q;
					end
				end
				default: ;
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign sum_num   = sum_num_q;
	assign sum_den   = sum_den_q;

	ap_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> busy_q && pc_q == '0)
		else $error("transaction accepted but sequencer not started");

	ap_rise_from_finish: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(busy_q) && !busy_q)
		else $error("output valid raised outside finish step");

	ap_subswap_odd: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q && uw.op == OP_SUBSWAP |-> x_q[0] && y_q[0])
		else $error("GCD subtract with an even operand");

	ap_div_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q && uw.op == OP_DIV_STEP |-> x_q != '0)
		else $error("divide by zero GCD");

	ap_zero_over_one: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && sum_num_q == '0 |-> sum_den_q == DEN_W'(1))
		else $error("zero sum not reported as 0/1");

endmodule

// File: dv/tb_fraction_add_reduce.sv
// ----------------------------------------------------------------------------
// tb_fraction_add_reduce
// Self-checking bench for the fraction adder. A behavioural model computes
// the reduced sum of each accepted transaction. Every accepted result is
// compared field by field against the oldest outstanding prediction. Stimulus
// is a short directed set (extremes, zero sums, zero denominators) followed
// by constrained-by-hand random fractions. Both sides idle at random, and the
// receiver holds off once for long enough to back the block up.
// ----------------------------------------------------------------------------
module tb_fraction_add_reduce;

	timeunit 1ns;
	timeprecision 1ps;

	import far_pkg::*;

	localparam int unsigned CYCLE_LIMIT  = 5_000_000;
	localparam int          RANDOM_ITEMS = 2000;
	localparam int          DRAIN_CYCLES = 250;
	localparam int          HOLD_AT      = 300;
	localparam int          HOLD_CYCLES  = 600;
	localparam int          MAX_REPORTS  = 25;

	class fraction_board;
		typedef struct {
			num_t num;
			den_t den;
		} reduced_t;

		reduced_t    sums_q[$];
		int unsigned errors  = 0;
		int unsigned noted   = 0;
		int unsigned checked = 0;

		// Predict the reduced sum of one accepted transaction.
		function void note_operands(operand_t na, operand_t da, operand_t nb, operand_t db);
			logic [63:0] n;
			logic [63:0] d;
			logic [63:0] x;
			logic [63:0] y;
			logic [63:0] r;
			reduced_t    e;
			n = 64'(na) * 64'(db) + 64'(nb) * 64'(da);
			d = 64'(da) * 64'(db);
			if (n == 64'd0) begin
				e.num = num_t'(0);
				e.den = den_t'(1);
			end else begin
				x = n;
				y = d;
				while (y != 64'd0) begin
					r = x % y;
					x = y;
					y = r;
				end
				if (x == 64'd0)
					x = 64'd1;
				e.num = num_t'(n / x);
				e.den = den_t'(d / x);
			end
			sums_q.push_back(e);
			noted++;
		endfunction

		function void check_sum(num_t num, den_t den);
			reduced_t e;
			if (sums_q.size() == 0) begin
				errors++;
				if (errors <= MAX_REPORTS)
					$display("%0t: unexpected result %0d/%0d, nothing outstanding",
						$time, num, den);
				return;
			end
			e = sums_q.pop_front();
			checked++;
			if (num !== e.num) begin
				errors++;
				if (errors <= MAX_REPORTS)
					$display("%0t: sum_num expected %0d actual %0d", $time, e.num, num);
			end
			if (den !== e.den) begin
				errors++;
				if (errors <= MAX_REPORTS)
					$display("%0t: sum_den expected %0d actual %0d", $time, e.den, den);
			end
		endfunction
	endclass

	logic     clk       = 1'b0;
	logic     arst_n    = 1'b0;
	logic     in_valid  = 1'b0;
	operand_t num_a     = '0;
	operand_t den_a     = '0;
	operand_t num_b     = '0;
	operand_t den_b     = '0;
	logic     out_stall = 1'b0;
	logic     in_stall;
	logic     out_valid;
	num_t     sum_num;
	den_t     sum_den;

	fraction_board board = new();
	int unsigned   cycles = 0;
	int            sent   = 0;
	int            taken  = 0;

	fraction_add_reduce dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.num_a     (num_a),
		.den_a     (den_a),
		.num_b     (num_b),
		.den_b     (den_b),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sum_num   (sum_num),
		.sum_den   (sum_den)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d outstanding", cycles, board.sums_q.size());
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// Transaction monitors: sampled before the edge's updates land.
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall)
				board.note_operands(num_a, den_a, num_b, den_b);
			if (out_valid && !out_stall)
				board.check_sum(sum_num, sum_den);
		end
	end

	task automatic send_pair(input operand_t na, input operand_t da,
			input operand_t nb, input operand_t db);
		int gap;
		gap = (((sent / 160) % 4) == 3) ? 0 : $urandom_range(0, 14);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		num_a    <= na;
		den_a    <= da;
		num_b    <= nb;
		den_b    <= db;
		do @(posedge clk); while (in_stall);
		sent++;
	endtask

	// Receiver: random stalls per result, quiet stretches, one long hold-off.
	initial begin
		int w;
		wait (arst_n);
		forever begin
			if (taken == HOLD_AT)
				w = HOLD_CYCLES;
			else if (((taken / 140) % 4) == 2)
				w = 0;
			else
				w = $urandom_range(0, 14);
			if (w > 0) begin
				out_stall <= 1'b1;
				repeat (w) @(posedge clk);
				out_stall <= 1'b0;
			end
			do @(posedge clk); while (!out_valid);
			taken++;
		end
	end

	initial begin
		int       kind;
		int       k;
		operand_t na;
		operand_t da;
		operand_t nb;
		operand_t db;

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_pair(0, 1, 0, 1);
		send_pair(0, 0, 0, 0);
		send_pair(65535, 65535, 65535, 65535);
		send_pair(65535, 1, 65535, 1);
		send_pair(1, 65535, 65534, 65535);
		send_pair(1, 65535, 1, 65534);
		send_pair(0, 65535, 0, 1);
		send_pair(5, 0, 3, 7);
		send_pair(5, 7, 3, 0);
		send_pair(0, 0, 3, 7);
		send_pair(7, 0, 0, 5);
		send_pair(65535, 0, 65535, 65535);
		send_pair(1, 2, 1, 2);
		send_pair(1, 3, 1, 6);
		send_pair(1, 32768, 1, 32768);
		send_pair(32768, 1, 32768, 1);
		send_pair(1, 1, 0, 65535);
		send_pair(65535, 2, 1, 2);
		send_pair(12345, 54321, 54321, 12345);
		send_pair(1, 65521, 1, 65519);
		send_pair(43690, 21845, 21845, 43690);
		send_pair(65535, 65535, 0, 1);

		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			kind = $urandom_range(0, 9);
			case (kind)
				0, 1, 2, 3: begin
					na = operand_t'($urandom);
					da = operand_t'($urandom);
					nb = operand_t'($urandom);
					db = operand_t'($urandom);
				end
				4, 5: begin
					na = operand_t'($urandom_range(0, 20));
					da = operand_t'($urandom_range(1, 20));
					nb = operand_t'($urandom_range(0, 20));
					db = operand_t'($urandom_range(1, 20));
				end
				6: begin
					k  = $urandom_range(2, 255);
					na = operand_t'(k * $urandom_range(0, 255));
					da = operand_t'(k * $urandom_range(1, 255));
					nb = operand_t'(k * $urandom_range(0, 255));
					db = operand_t'(k * $urandom_range(1, 255));
				end
				7: begin
					na = operand_t'(1 << $urandom_range(0, 15));
					da = operand_t'(1 << $urandom_range(0, 15));
					nb = operand_t'(1 << $urandom_range(0, 15));
					db = operand_t'(1 << $urandom_range(0, 15));
				end
				8: begin
					na = ($urandom_range(0, 1) == 0) ? '0 : operand_t'($urandom);
					da = operand_t'($urandom_range(1, 65535));
					nb = '0;
					db = operand_t'($urandom_range(1, 65535));
				end
				default: begin
					na = operand_t'($urandom);
					da = operand_t'($urandom_range(1, 65535));
					if ($urandom_range(0, 1) == 0) begin
						nb = na;
						db = da;
					end else begin
						nb = operand_t'($urandom);
						db = '0;
					end
				end
			endcase
			if ($urandom_range(0, 1) == 0)
				send_pair(na, da, nb, db);
			else
				send_pair(nb, db, na, da);
		end
		in_valid <= 1'b0;
		@(posedge clk);

		while (board.sums_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("%0d transactions sent (22 directed), %0d results checked, %0d errors",
			sent, board.checked, board.errors);
		$display("covered zero sums, zero denominators, extremes and a %0d-cycle receiver hold",
			HOLD_CYCLES);
		if (board.errors == 0 && board.sums_q.size() == 0 && board.noted == sent) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
